FILE: rtl/fscp_pkg.sv
// fscp_pkg: shared types and constants for the frame slot cache policy.
// Used by the channel interfaces, the controller and the datapath.
package fscp_pkg;

  // Field widths of the channel words
  localparam int unsigned OP_FIELD_W    = 1;
  localparam int unsigned ANIM_FIELD_W  = 12;
  localparam int unsigned FRAME_FIELD_W = 16;
  localparam int unsigned SLOT_FIELD_W  = 5;

  // Request operation codes
  typedef enum logic [OP_FIELD_W-1:0] {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } fscp_op_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fscp_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch request word and its compare results
    logic commit;   // apply the update and load the result register
  } fscp_cmd_t;

endpackage

FILE: rtl/fscp_if.sv
// fscp_if: valid/ready channels for request and result words.
// Depends on fscp_pkg for field widths.
interface fscp_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [fscp_pkg::OP_FIELD_W-1:0]        opcode;
  logic [fscp_pkg::ANIM_FIELD_W-1:0]      anim_id;
  logic [fscp_pkg::FRAME_FIELD_W-1:0]     frame_id;

  modport source (output valid, output opcode, output anim_id, output frame_id, input ready);
  modport sink   (input valid, input opcode, input anim_id, input frame_id, output ready);
endinterface

interface fscp_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [fscp_pkg::SLOT_FIELD_W-1:0]      slot;
  logic                                   hit;
  logic                                   needs_fill;
  logic                                   full_res;

  modport source (output valid, output slot, output hit, output needs_fill, output full_res,
                  input ready);
  modport sink   (input valid, input slot, input hit, input needs_fill, input full_res,
                  output ready);
endinterface

FILE: rtl/fscp_ctrl.sv
// fscp_ctrl: two-state controller that sequences capture and commit and
// owns the result valid flag. Depends on fscp_pkg.
module fscp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output fscp_pkg::fscp_cmd_t cmd_o
);

  fscp_pkg::fscp_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic accept;

  // Result register can take a new word when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && (state_q == fscp_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fscp_pkg::S_IDLE: begin
        if (accept) state_d = fscp_pkg::S_EXEC;
      end
      fscp_pkg::S_EXEC: begin
        if (out_free) state_d = fscp_pkg::S_IDLE;
      end
      default: state_d = fscp_pkg::S_IDLE;
    endcase
  end

  // Outputs: commands and handshake
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      fscp_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      fscp_pkg::S_EXEC: begin
        cmd_o.commit = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Hold valid until the word is taken; set it on commit
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fscp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/fscp_dp.sv
// fscp_dp: tag store, in-use marks, victim pointer, parallel tag compare,
// circular free-slot search and result register. Depends on fscp_pkg.
module fscp_dp #(
  parameter int unsigned NUM_SLOTS  = 32,
  parameter int unsigned ANIM_BITS  = 12,
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fscp_pkg::fscp_cmd_t                 cmd_i,
  input  logic [fscp_pkg::OP_FIELD_W-1:0]     opcode_i,
  input  logic [fscp_pkg::ANIM_FIELD_W-1:0]   anim_id_i,
  input  logic [fscp_pkg::FRAME_FIELD_W-1:0]  frame_id_i,
  output logic [fscp_pkg::SLOT_FIELD_W-1:0]   slot_o,
  output logic                                hit_o,
  output logic                                needs_fill_o,
  output logic                                full_res_o
);

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // Slot state
  logic [ANIM_BITS-1:0]  tag_anim_q  [NUM_SLOTS];
  logic [FRAME_BITS-1:0] tag_frame_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  in_use_q, in_use_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;

  // Captured request and compare results
  logic [fscp_pkg::OP_FIELD_W-1:0] op_q;
  logic [ANIM_BITS-1:0]  anim_q, anim_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [NUM_SLOTS-1:0]  match_q, match_d;
  logic [NUM_SLOTS-1:0]  free_hi_q, free_hi_d;
  logic [NUM_SLOTS-1:0]  free_all_q;

  // Result register
  logic [fscp_pkg::SLOT_FIELD_W-1:0] slot_q, slot_d;
  logic hit_q, hit_d, fill_q, fill_d, full_q, full_d;

  // Commit-side decode
  logic [NUM_SLOTS-1:0] match_lsb, hi_lsb, all_lsb;
  logic [IDX_W-1:0]     hit_idx, hi_idx, all_idx, victim_idx;
  logic                 tag_we;

  // Reduce request tags to the stored width and compare against every slot
  always_comb begin
    anim_d  = ANIM_BITS'(anim_id_i);
    frame_d = FRAME_BITS'(frame_id_i);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_d[i]   = (tag_anim_q[i] == anim_d) && (tag_frame_q[i] == frame_d);
      free_hi_d[i] = !in_use_q[i] && (IDX_W'(i) >= ptr_q);
    end
  end

  // Isolate the lowest set bit of each candidate vector and encode it
  assign match_lsb = match_q & (~match_q + 1'b1);
  assign hi_lsb    = free_hi_q & (~free_hi_q + 1'b1);
  assign all_lsb   = free_all_q & (~free_all_q + 1'b1);

  always_comb begin
    hit_idx = '0;
    hi_idx  = '0;
    all_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_idx = hit_idx | ({IDX_W{match_lsb[i]}} & IDX_W'(i));
      hi_idx  = hi_idx  | ({IDX_W{hi_lsb[i]}}    & IDX_W'(i));
      all_idx = all_idx | ({IDX_W{all_lsb[i]}}   & IDX_W'(i));
    end
  end

  // Circular search: first free at or above the pointer, else wrap to lowest
  assign victim_idx = (|free_hi_q) ? hi_idx : all_idx;

  // Apply the operation and form the result word
  always_comb begin
    in_use_d = in_use_q;
    ptr_d    = ptr_q;
    tag_we   = 1'b0;
    slot_d   = slot_q;
    hit_d    = hit_q;
    fill_d   = fill_q;
    full_d   = full_q;
    if (cmd_i.commit) begin
      slot_d = '0;
      hit_d  = 1'b0;
      fill_d = 1'b0;
      full_d = 1'b0;
      priority if (op_q == fscp_pkg::OP_CLEAR) begin
        in_use_d = '0;
      end else if (|match_q) begin
        in_use_d[hit_idx] = 1'b1;
        slot_d            = fscp_pkg::SLOT_FIELD_W'(hit_idx);
        hit_d             = 1'b1;
      end else if (|free_all_q) begin
        in_use_d[victim_idx] = 1'b1;
        tag_we               = 1'b1;
        ptr_d                = (victim_idx == LAST_IDX) ? '0 : victim_idx + 1'b1;
        slot_d               = fscp_pkg::SLOT_FIELD_W'(victim_idx);
        fill_d               = 1'b1;
      end else begin
        full_d = 1'b1;
      end
    end
  end

  // Slot state registers; tags reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      ptr_q    <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tag_anim_q[i]  <= '0;
        tag_frame_q[i] <= '0;
      end
    end else begin
      in_use_q <= in_use_d;
      ptr_q    <= ptr_d;
      if (tag_we) begin
        tag_anim_q[victim_idx]  <= anim_q;
        tag_frame_q[victim_idx] <= frame_q;
      end
    end
  end

  // Capture the request word and its compare vectors
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= opcode_i;
      anim_q     <= anim_d;
      frame_q    <= frame_d;
      match_q    <= match_d;
      free_hi_q  <= free_hi_d;
      free_all_q <= ~in_use_q;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    hit_q  <= hit_d;
    fill_q <= fill_d;
    full_q <= full_d;
  end

  assign slot_o       = slot_q;
  assign hit_o        = hit_q;
  assign needs_fill_o = fill_q;
  assign full_res_o   = full_q;

endmodule

FILE: rtl/frame_slot_cache_policy.sv
// frame_slot_cache_policy: round-robin free-slot policy for a
// fully associative frame cache. A request word is captured when accepted
// and its result registered on commit (later while the result register waits).
// A new word is accepted only after the last one commits, in capture/commit sequence.
// Reset: tags zero, in-use marks clear, victim pointer zero; ready at once.
// Depends on fscp_pkg, fscp_req_if, fscp_rsp_if, fscp_ctrl and fscp_dp.
module frame_slot_cache_policy #(
  parameter int unsigned NUM_SLOTS  = 32,
  parameter int unsigned ANIM_BITS  = 12,
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fscp_req_if.sink   in_i,
  fscp_rsp_if.source out_o
);

  fscp_pkg::fscp_cmd_t cmd;

  // Sequencing
  fscp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // Slot state and lookup logic
  fscp_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .ANIM_BITS  (ANIM_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (in_i.opcode),
    .anim_id_i    (in_i.anim_id),
    .frame_id_i   (in_i.frame_id),
    .slot_o       (out_o.slot),
    .hit_o        (out_o.hit),
    .needs_fill_o (out_o.needs_fill),
    .full_res_o   (out_o.full_res)
  );

endmodule

FILE: tb/frame_slot_cache_policy_tb.sv
// frame_slot_cache_policy_tb: self-checking bench for the frame slot cache policy.
// Drives request words and checks every result word against a slot-state predictor.
// Depends on fscp_pkg, fscp_req_if, fscp_rsp_if and frame_slot_cache_policy.
`timescale 1ns / 100ps

module frame_slot_cache_policy_tb;

  localparam int NUM_SLOTS       = 32;
  localparam int TAIL_WORDS      = 120;
  localparam int HOLD_AFTER      = 400;
  localparam int LONG_HOLD_CYC   = 150;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int SETTLE_CYC      = 20;
  localparam int RANDOM_WORDS    = 1700;
  localparam int MAX_PRINTED     = 40;
  localparam int POOL_MAX        = 64;

  typedef logic [fscp_pkg::ANIM_FIELD_W-1:0]  anim_t;
  typedef logic [fscp_pkg::FRAME_FIELD_W-1:0] frame_t;

  typedef struct {
    fscp_pkg::fscp_op_e                 op;
    logic [fscp_pkg::ANIM_FIELD_W-1:0]  anim;
    logic [fscp_pkg::FRAME_FIELD_W-1:0] frame;
  } req_word_t;

  typedef struct {
    logic [fscp_pkg::SLOT_FIELD_W-1:0] slot;
    logic                              hit;
    logic                              needs_fill;
    logic                              full_res;
  } slot_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Bench-side copies of the driven channel signals, known from time zero
  logic                               req_valid = 1'b0;
  fscp_pkg::fscp_op_e                 req_op    = fscp_pkg::OP_LOOKUP;
  logic [fscp_pkg::ANIM_FIELD_W-1:0]  req_anim  = '0;
  logic [fscp_pkg::FRAME_FIELD_W-1:0] req_frame = '0;
  logic                               rsp_ready = 1'b0;
  logic                               long_hold = 1'b0;

  fscp_req_if req_ch ();
  fscp_rsp_if rsp_ch ();

  assign req_ch.valid    = req_valid;
  assign req_ch.opcode   = req_op;
  assign req_ch.anim_id  = req_anim;
  assign req_ch.frame_id = req_frame;
  assign rsp_ch.ready    = rsp_ready;

  frame_slot_cache_policy i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: tags, in-use marks and the allocation pointer
  logic [fscp_pkg::ANIM_FIELD_W-1:0]  cached_anim  [NUM_SLOTS];
  logic [fscp_pkg::FRAME_FIELD_W-1:0] cached_frame [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]               slot_marked  = '0;
  int                                 alloc_ptr    = 0;

  req_word_t    req_pending [$];
  slot_result_t slot_results_due [$];
  int           words_total    = 0;
  int           words_accepted = 0;
  int           results_seen   = 0;
  int           error_count    = 0;
  int           src_idle_pct   = 20;
  int           sink_idle_pct  = 20;
  int           src_words      = 0;
  int           sink_words     = 0;
  int           gap_left       = 0;
  int           stall_left     = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cached_anim[i]  = '0;
      cached_frame[i] = '0;
    end
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Work out the result of one request word and update the slot state
  function automatic slot_result_t predict_slot_result(
      input fscp_pkg::fscp_op_e op,
      input logic [fscp_pkg::ANIM_FIELD_W-1:0] anim,
      input logic [fscp_pkg::FRAME_FIELD_W-1:0] frame);
    slot_result_t res;
    bit           found;
    int           probe;
    int           n;
    res   = '{slot: '0, hit: 1'b0, needs_fill: 1'b0, full_res: 1'b0};
    found = 1'b0;
    if (op == fscp_pkg::OP_CLEAR) begin
      slot_marked = '0;
      return res;
    end
    // Lowest matching tag wins
    for (n = 0; n < NUM_SLOTS && !found; n++) begin
      if (cached_anim[n] == anim && cached_frame[n] == frame) begin
        slot_marked[n] = 1'b1;
        res.slot = n[fscp_pkg::SLOT_FIELD_W-1:0];
        res.hit  = 1'b1;
        found    = 1'b1;
      end
    end
    if (found) return res;
    // Probe round-robin from the pointer for the first unmarked slot
    probe = alloc_ptr;
    for (n = 0; n < NUM_SLOTS && !found; n++) begin
      if (!slot_marked[probe]) begin
        cached_anim[probe]  = anim;
        cached_frame[probe] = frame;
        slot_marked[probe]  = 1'b1;
        alloc_ptr           = (probe + 1) % NUM_SLOTS;
        res.slot            = probe[fscp_pkg::SLOT_FIELD_W-1:0];
        res.needs_fill      = 1'b1;
        found               = 1'b1;
      end else begin
        probe = (probe + 1) % NUM_SLOTS;
      end
    end
    if (!found) res.full_res = 1'b1;
    return res;
  endfunction

  task automatic push_lookup(input logic [fscp_pkg::ANIM_FIELD_W-1:0] anim,
                             input logic [fscp_pkg::FRAME_FIELD_W-1:0] frame);
    req_pending.push_back('{op: fscp_pkg::OP_LOOKUP, anim: anim, frame: frame});
  endtask

  task automatic push_clear();
    req_pending.push_back('{op: fscp_pkg::OP_CLEAR, anim: anim_t'($urandom),
                            frame: frame_t'($urandom)});
  endtask

  function automatic logic [fscp_pkg::ANIM_FIELD_W-1:0] rand_anim();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return anim_t'($urandom);
    endcase
  endfunction

  function automatic logic [fscp_pkg::FRAME_FIELD_W-1:0] rand_frame();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return frame_t'($urandom);
    endcase
  endfunction

  // Fill the queue of request words, then wait for the run to finish
  initial begin : stimulus
    logic [fscp_pkg::ANIM_FIELD_W-1:0]  pool_anim  [POOL_MAX];
    logic [fscp_pkg::FRAME_FIELD_W-1:0] pool_frame [POOL_MAX];
    int pool_size;
    int seg_len;
    int clear_pct;
    int fresh_pct;
    int pick;
    int drain;

    // Directed: reset tags, field extremes, clears with ignored ids
    push_lookup('0, '0);
    push_lookup('0, '0);
    push_lookup('1, '1);
    push_lookup('1, '1);
    push_lookup('0, '1);
    push_lookup('1, '0);
    req_pending.push_back('{op: fscp_pkg::OP_CLEAR, anim: '1, frame: '1});
    push_lookup(12'h001, 16'h0001);
    push_lookup(12'h800, 16'h8000);
    push_lookup(12'h555, 16'hAAAA);
    push_lookup(12'hAAA, 16'h5555);
    push_lookup('1, '1);
    req_pending.push_back('{op: fscp_pkg::OP_CLEAR, anim: '0, frame: '0});
    push_lookup('0, '0);
    push_lookup(12'h800, 16'h8000);
    push_lookup(12'h7FF, 16'h7FFF);
    push_clear();

    // Random: segments over a working set of tags, so hits, fills and full all occur
    while (req_pending.size() < RANDOM_WORDS) begin
      case ($urandom_range(0, 5))
        0: pool_size = 3;
        1: pool_size = 8;
        2: pool_size = 24;
        3: pool_size = 31;
        4: pool_size = 33;
        default: pool_size = 48;
      endcase
      case ($urandom_range(0, 3))
        0, 1: clear_pct = 0;
        2:    clear_pct = 2;
        default: clear_pct = 8;
      endcase
      case ($urandom_range(0, 2))
        0: fresh_pct = 5;
        1: fresh_pct = 20;
        default: fresh_pct = 50;
      endcase
      seg_len = $urandom_range(20, 120);
      for (int k = 0; k < pool_size; k++) begin
        pool_anim[k]  = rand_anim();
        pool_frame[k] = rand_frame();
      end
      if ($urandom_range(0, 1) == 0) push_clear();
      for (int k = 0; k < seg_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < clear_pct) begin
          push_clear();
        end else if (pick < clear_pct + fresh_pct) begin
          push_lookup(rand_anim(), rand_frame());
        end else begin
          pick = $urandom_range(0, pool_size - 1);
          push_lookup(pool_anim[pick], pool_frame[pick]);
        end
      end
    end
    words_total = req_pending.size();

    // Hold reset, then release it away from the active edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (words_accepted != words_total) @(posedge clk_i);
    drain = 0;
    while (slot_results_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (slot_results_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", slot_results_due.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Drive request words, with random idle bursts outside the tail
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    req_word_t next_word;
    if (!rst_ni) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else if (!req_valid || req_ch.ready) begin
      if (gap_left != 0) begin
        req_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (req_pending.size() >= TAIL_WORDS &&
                   $urandom_range(0, 99) < src_idle_pct) begin
        req_valid <= 1'b0;
        gap_left  <= $urandom_range(0, 12);
      end else if (req_pending.size() != 0) begin
        next_word = req_pending.pop_front();
        req_valid <= 1'b1;
        req_op    <= next_word.op;
        req_anim  <= next_word.anim;
        req_frame <= next_word.frame;
        src_words <= src_words + 1;
        // Change the idle density every 64 words, often to none
        if (src_words % 64 == 63) begin
          case ($urandom_range(0, 3))
            0, 1: src_idle_pct <= 0;
            2:    src_idle_pct <= 15;
            default: src_idle_pct <= 40;
          endcase
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Drive result ready with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else if (long_hold) begin
      rsp_ready <= 1'b0;
    end else if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (req_pending.size() >= TAIL_WORDS &&
                 $urandom_range(0, 99) < sink_idle_pct) begin
      rsp_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Change the stall density every 64 result words
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      sink_words <= sink_words + 1;
      if (sink_words % 64 == 63) begin
        case ($urandom_range(0, 3))
          0, 1: sink_idle_pct <= 0;
          2:    sink_idle_pct <= 15;
          default: sink_idle_pct <= 40;
        endcase
      end
    end
  end

  // Hold off the result side long enough to back the block up into its input
  initial begin
    while (words_accepted < HOLD_AFTER) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYC) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Check result words, then predict from accepted request words
  always @(posedge clk_i) begin : monitor
    slot_result_t due;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (slot_results_due.size() == 0) begin
          flag_error($sformatf("result %0d with nothing expected: slot %0d", results_seen,
                               rsp_ch.slot));
        end else begin
          due = slot_results_due.pop_front();
          if (rsp_ch.slot !== due.slot)
            flag_error($sformatf("result %0d slot %0d expected %0d", results_seen,
                                 rsp_ch.slot, due.slot));
          if (rsp_ch.hit !== due.hit)
            flag_error($sformatf("result %0d hit %0b expected %0b", results_seen,
                                 rsp_ch.hit, due.hit));
          if (rsp_ch.needs_fill !== due.needs_fill)
            flag_error($sformatf("result %0d needs_fill %0b expected %0b", results_seen,
                                 rsp_ch.needs_fill, due.needs_fill));
          if (rsp_ch.full_res !== due.full_res)
            flag_error($sformatf("result %0d full_res %0b expected %0b", results_seen,
                                 rsp_ch.full_res, due.full_res));
        end
        results_seen <= results_seen + 1;
      end
      if (req_ch.valid && req_ch.ready) begin
        slot_results_due.push_back(predict_slot_result(fscp_pkg::fscp_op_e'(req_ch.opcode),
                                                       req_ch.anim_id, req_ch.frame_id));
        words_accepted <= words_accepted + 1;
      end
    end
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
